@@ hdl/wuc_pkg.sv @@
// Package for the way use counter block: request and response payloads,
// operation codes, sequencer states and the per-cell command.
// No dependencies.
`timescale 1ns / 1ps

package wuc_pkg;

   localparam int COUNT_W   = 4;
   localparam int WAY_W     = 4;
   localparam int LOG_W     = 3;
   localparam int NUM_CODES = 16;   // way field codes seen on the request

   localparam logic [COUNT_W-1:0] COUNT_TOP     = 4'd15;
   localparam logic [COUNT_W-1:0] COUNT_FALLBACK = 4'd8;
   localparam logic [LOG_W-1:0]   LOG_RESET     = 3'd4;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_INCR  = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_SCAN = 2'd2,
      S_DONE = 2'd3
   } state_type;

   typedef struct packed {
      kind_type           kind;
      logic [WAY_W-1:0]   way;
      logic [COUNT_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               is_protected;
   } rsp_type;

   typedef struct packed {
      logic               write_en;
      logic               incr_en;
      logic [COUNT_W-1:0] value;
   } cell_cmd_type;

endpackage

@@ hdl/way_use_counters_protect_check_unit.sv @@
// Top level of the way use counter block: request sequencer, counter chain,
// protect decision and response register.
// Depends on wuc_pkg and wuc_cell.
`timescale 1ns / 1ps

// Usage
//   Requests (req_valid / req_stall / req_payload) carry one operation on one
//   way: read, write, increment, or protect query. Each request yields one
//   response (rsp_valid / rsp_stall / rsp_payload) with the way's count after
//   the operation and the protect flag (set only by a query).
//   The block works on one request at a time; req_stall is high while one is
//   in progress. Read, write and increment pass the execute and finishing
//   steps before the response is loaded; a query also waits in the scan step
//   while the tally token walks one cell per cycle down the chain of MAX_WAYS
//   counter cells. The next request can be taken in the cycle after the
//   response is loaded, and no earlier.
//   The response register holds its payload while rsp_stall is high; a new
//   request is still accepted meanwhile, and its result waits in the
//   sequencer until the response register frees up.
//   csr_write_enable / csr_write_data load the log2 active-way count; write
//   it only while the block is idle.
//   Reset (synchronous) clears all counters to zero, sets the log register
//   to 4 and empties the response register.
module way_use_counters_protect_check_unit #(
   parameter int MAX_WAYS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  wuc_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output wuc_pkg::rsp_type              rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [wuc_pkg::LOG_W-1:0]     csr_write_data
);
   import wuc_pkg::*;

   localparam int IDX_W = $clog2(MAX_WAYS);
   localparam int SUM_W = $clog2(MAX_WAYS+1);
   localparam int POW_W = 2**LOG_W;
   localparam logic [POW_W-1:0] MaxWaysPow = POW_W'(MAX_WAYS);

   state_type          state_ff, state_in;
   kind_type           kind_ff;
   logic [IDX_W-1:0]   widx_ff;
   logic [COUNT_W-1:0] value_ff;
   logic [COUNT_W-1:0] tgt_ff;
   logic               prot_ff;
   logic               launch_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic [LOG_W-1:0]   ways_log_ff;

   logic               accept;
   logic               exec_go;
   logic               scan_done;
   logic               rsp_load;

   logic [IDX_W-1:0]   wrap_table [NUM_CODES];
   logic [COUNT_W-1:0] cell_count [MAX_WAYS];
   cell_cmd_type       cell_cmd   [MAX_WAYS];
   logic               token_chain [MAX_WAYS+1];
   logic [SUM_W-1:0]   sum_chain   [MAX_WAYS+1];
   logic [MAX_WAYS-1:0] token_vec;
   logic [COUNT_W-1:0] sel_count;
   logic [POW_W-1:0]   pow_ways;
   logic [SUM_W-1:0]   active_n;
   logic [SUM_W-1:0]   half_n;

   // way code to counter index, wrapped by the way count
   for (genvar g = 0; g < NUM_CODES; g++) begin : g_wrap
      localparam int WrapIdx = g % MAX_WAYS;
      assign wrap_table[g] = IDX_W'(WrapIdx);
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and step strobes
   always_comb begin
      state_in  = state_ff;
      accept    = 1'b0;
      exec_go   = 1'b0;
      scan_done = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            accept = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            exec_go = 1'b1;
            if (kind_ff == KIND_QUERY) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (token_chain[MAX_WAYS]) begin
               scan_done = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   // hold the request fields for the duration of the operation
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_payload.kind;
         widx_ff  <= wrap_table[req_payload.way];
         value_ff <= req_payload.value;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         ways_log_ff <= LOG_RESET;
      end else if (csr_write_enable) begin
         ways_log_ff <= csr_write_data;
      end
   end

   // drive the addressed cell
   for (genvar i = 0; i < MAX_WAYS; i++) begin : g_cmd
      assign cell_cmd[i].write_en = exec_go && (kind_ff == KIND_WRITE) &&
                                    (widx_ff == IDX_W'(i));
      assign cell_cmd[i].incr_en  = exec_go && (kind_ff == KIND_INCR) &&
                                    (widx_ff == IDX_W'(i));
      assign cell_cmd[i].value    = value_ff;
   end

   // counter chain; the tally token enters at cell zero
   assign token_chain[0] = launch_ff;
   assign sum_chain[0]   = '0;

   for (genvar i = 0; i < MAX_WAYS; i++) begin : g_cell
      wuc_cell #(
         .MAX_WAYS (MAX_WAYS),
         .CELL_IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cell_cmd[i]),
         .target    (tgt_ff),
         .ways_log  (ways_log_ff),
         .token_in  (token_chain[i]),
         .sum_in    (sum_chain[i]),
         .token_out (token_chain[i+1]),
         .sum_out   (sum_chain[i+1]),
         .count     (cell_count[i])
      );
      assign token_vec[i] = token_chain[i+1];
   end

   assign sel_count = cell_count[widx_ff];

   // active ways capped at the way count, and half of that
   assign pow_ways = POW_W'(1) << ways_log_ff;
   assign active_n = (pow_ways > MaxWaysPow) ? SUM_W'(MAX_WAYS) : pow_ways[SUM_W-1:0];
   assign half_n   = active_n >> 1;

   // latch the target count, launch the token, capture the decision
   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff <= 1'b0;
      end else begin
         launch_ff <= exec_go && (kind_ff == KIND_QUERY);
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         tgt_ff  <= sel_count;
         prot_ff <= 1'b0;
      end else if (scan_done) begin
         prot_ff <= (sum_chain[MAX_WAYS] <= half_n);
      end
   end

   // response register; hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.count        <= sel_count;
         rsp_data_ff.is_protected <= prot_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // at most one tally token in flight along the chain
   a_token_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(token_vec))
      else $error("more than one tally token in the chain");

   // the token leaves the chain only while the sequencer waits for it
   a_token_exit: assert property (@(posedge clock) disable iff (reset)
      token_chain[MAX_WAYS] |-> (state_ff == S_SCAN))
      else $error("tally token left the chain outside a query scan");

   // a new response comes only from the finishing step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside the finishing step");

endmodule

@@ hdl/wuc_cell.sv @@
// One cell of the counter chain: holds one way's use counter and adds its
// compare result to the running tally handed along the chain.
// Depends on wuc_pkg.
`timescale 1ns / 1ps

module wuc_cell #(
   parameter int MAX_WAYS = 16,
   parameter int CELL_IDX = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wuc_pkg::cell_cmd_type               cmd,
   input  logic [wuc_pkg::COUNT_W-1:0]         target,
   input  logic [wuc_pkg::LOG_W-1:0]           ways_log,
   input  logic                                token_in,
   input  logic [$clog2(MAX_WAYS+1)-1:0]       sum_in,
   output logic                                token_out,
   output logic [$clog2(MAX_WAYS+1)-1:0]       sum_out,
   output logic [wuc_pkg::COUNT_W-1:0]         count
);
   import wuc_pkg::*;

   localparam int IDX_W = $clog2(MAX_WAYS);
   localparam int SUM_W = $clog2(MAX_WAYS+1);
   localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               token_ff;
   logic [SUM_W-1:0]   sum_ff, sum_in_next;
   logic               active;
   logic               hit;

   // load or bump the counter; at the top value it drops back to the fallback value
   always_comb begin
      count_in = count_ff;
      if (cmd.write_en) begin
         count_in = cmd.value;
      end else if (cmd.incr_en) begin
         if (count_ff == COUNT_TOP) begin
            count_in = COUNT_FALLBACK;
         end else begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   // this way takes part in the query when its index is below 2**log
   assign active      = ((MyIdx >> ways_log) == '0);
   assign hit         = active && (count_ff >= target);
   assign sum_in_next = sum_in + SUM_W'(hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         token_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         token_ff <= token_in;
      end
   end

   // advance the tally one cell per cycle
   always_ff @(posedge clock) begin
      sum_ff <= sum_in_next;
   end

   assign token_out = token_ff;
   assign sum_out   = sum_ff;
   assign count     = count_ff;

endmodule
